// ===== rtl/ktp_pkg.sv =====
// ----------------------------------------------------------------------------
// ktp_pkg
// Shared types, constants and helpers for the k-trade profit table block.
// ----------------------------------------------------------------------------
package ktp_pkg;

  localparam int MaxTradesDef = 16;
  localparam int PriceW       = 30;
  localparam int ProfitW      = 34;
  localparam int CfgW         = 5;
  localparam int ValW         = 40;

  localparam logic [ProfitW-1:0] OutMax = '1;

  typedef logic signed [ValW-1:0] val_t;

  // table entry: ok is low for minus infinity
  typedef struct packed {
    logic ok;
    val_t v;
  } ent_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SWEEP,
    ST_FINISH,
    ST_CLEAR
  } state_e;

  typedef struct packed {
    logic load;
    logic sweep;
    logic clear;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic out_free;
  } sts_t;

  // keep the larger of two entries, invalid loses
  function automatic ent_t take_max(ent_t a, ent_t c);
    ent_t r;
    r = a;
    if (c.ok && (!a.ok || (c.v > a.v))) begin
      r = c;
    end
    return r;
  endfunction

endpackage

// ===== rtl/k_transaction_trade_profit_dp_top.sv =====
// Day: K table entries (K = saturated limit) are updated one table entry per
//   cycle through the shared update unit, reading each memory once per cycle.
// Input: a new price waits for the previous day's sweep; a last day adds a
//   wait for the result slot plus a clearing pass over the table memories.
// Reset: limit returns to 1; a clearing pass runs before the first price is
//   taken.
// ----------------------------------------------------------------------------
// k_transaction_trade_profit_dp_top
// Streaming best profit over at most K long or short trades.
// ----------------------------------------------------------------------------
module k_transaction_trade_profit_dp_top #(
  parameter int MaxTrades = ktp_pkg::MaxTradesDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [ktp_pkg::CfgW-1:0]    cfg_data_i,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [ktp_pkg::PriceW-1:0]  price_i,
  input  logic                        last_day_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [ktp_pkg::ProfitW-1:0] max_profit_o
);
  import ktp_pkg::*;

  localparam int AW = (MaxTrades > 1) ? $clog2(MaxTrades) : 1;
  localparam int CW = $clog2(MaxTrades + 1);

  cmd_t cmd;
  sts_t sts;
  logic [AW-1:0] rd_addr, wr_addr;

  // sequencer
  ktp_ctrl #(
    .MaxTrades (MaxTrades),
    .AW        (AW),
    .CW        (CW)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .last_day_i (last_day_i),
    .in_stall_o (in_stall_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i),
    .sts_i      (sts),
    .cmd_o      (cmd),
    .rd_addr_o  (rd_addr),
    .wr_addr_o  (wr_addr)
  );

  // tables and arithmetic
  ktp_dp #(
    .MaxTrades (MaxTrades),
    .AW        (AW)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .rd_addr_i    (rd_addr),
    .wr_addr_i    (wr_addr),
    .price_i      (price_i),
    .out_stall_i  (out_stall_i),
    .sts_o        (sts),
    .out_valid_o  (out_valid_o),
    .max_profit_o (max_profit_o)
  );

endmodule

// ===== rtl/ktp_dp.sv =====
// ----------------------------------------------------------------------------
// ktp_dp
// Datapath: flat/long/short tables in memories, per-entry update, running
// best, and the result register.
// ----------------------------------------------------------------------------
module ktp_dp #(
  parameter int MaxTrades = ktp_pkg::MaxTradesDef,
  parameter int AW        = (MaxTrades > 1) ? $clog2(MaxTrades) : 1
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  ktp_pkg::cmd_t               cmd_i,
  input  logic [AW-1:0]               rd_addr_i,
  input  logic [AW-1:0]               wr_addr_i,
  input  logic [ktp_pkg::PriceW-1:0]  price_i,
  input  logic                        out_stall_i,
  output ktp_pkg::sts_t               sts_o,
  output logic                        out_valid_o,
  output logic [ktp_pkg::ProfitW-1:0] max_profit_o
);
  import ktp_pkg::*;

  // flat_m[a] holds flat entry a+1; flat entry 0 is always 0
  ent_t flat_m  [MaxTrades];
  ent_t long_m  [MaxTrades];
  ent_t short_m [MaxTrades];

  ent_t flat_rd_q, long_rd_q, short_rd_q;
  ent_t prev_q;
  val_t best_q;
  logic [PriceW-1:0] price_q;
  logic out_valid_q;
  logic [ProfitW-1:0] profit_q;

  val_t p;
  ent_t cl, cs, ol, os;
  ent_t nf, nl, ns;
  ent_t wf, wl, ws;
  logic we;

  // candidates and merges for one trade count
  always_comb begin
    p     = val_t'({{(ValW-PriceW){1'b0}}, price_q});
    cl.ok = long_rd_q.ok;
    cl.v  = long_rd_q.v + p;
    cs.ok = short_rd_q.ok;
    cs.v  = short_rd_q.v - p;
    nf    = take_max(take_max(flat_rd_q, cl), cs);
    ol.ok = prev_q.ok;
    ol.v  = prev_q.v - p;
    os.ok = prev_q.ok;
    os.v  = prev_q.v + p;
    nl    = take_max(long_rd_q, ol);
    ns    = take_max(short_rd_q, os);
    we    = cmd_i.sweep | cmd_i.clear;
    wf    = cmd_i.clear ? ent_t'('0) : nf;
    wl    = cmd_i.clear ? ent_t'('0) : nl;
    ws    = cmd_i.clear ? ent_t'('0) : ns;
  end

  // table memories, registered read
  always_ff @(posedge clk_i) begin
    if (we) begin
      flat_m[wr_addr_i]  <= wf;
      long_m[wr_addr_i]  <= wl;
      short_m[wr_addr_i] <= ws;
    end
    flat_rd_q  <= flat_m[rd_addr_i];
    long_rd_q  <= long_m[rd_addr_i];
    short_rd_q <= short_m[rd_addr_i];
  end

  // day price, old flat of previous count, running best
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      price_q   <= price_i;
      prev_q.ok <= 1'b1;
      prev_q.v  <= '0;
      best_q    <= '0;
    end else if (cmd_i.sweep) begin
      prev_q <= flat_rd_q;
      if (nf.ok && (nf.v > best_q)) begin
        best_q <= nf.v;
      end
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      if (best_q > val_t'({{(ValW-ProfitW){1'b0}}, OutMax})) begin
        profit_q <= OutMax;
      end else begin
        profit_q <= best_q[ProfitW-1:0];
      end
    end
  end

  assign sts_o.out_free = !out_valid_q || !out_stall_i;
  assign out_valid_o    = out_valid_q;
  assign max_profit_o   = profit_q;

`ifndef SYNTHESIS
  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |-> (!out_valid_q || !out_stall_i))
    else $error("result overwritten while stalled");
  a_best_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |-> (best_q >= 0))
    else $error("negative best profit");
  a_one_op: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_i.sweep && cmd_i.clear))
    else $error("sweep and clear together");
`endif

endmodule

// ===== rtl/ktp_ctrl.sv =====
// ----------------------------------------------------------------------------
// ktp_ctrl
// Controller: limit register, day sweep over trade counts, result hand-off
// and table clearing pass.
// ----------------------------------------------------------------------------
module ktp_ctrl #(
  parameter int MaxTrades = ktp_pkg::MaxTradesDef,
  parameter int AW        = (MaxTrades > 1) ? $clog2(MaxTrades) : 1,
  parameter int CW        = $clog2(MaxTrades + 1)
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  input  logic                     last_day_i,
  output logic                     in_stall_o,
  input  logic                     cfg_we_i,
  input  logic [ktp_pkg::CfgW-1:0] cfg_data_i,
  input  ktp_pkg::sts_t            sts_i,
  output ktp_pkg::cmd_t            cmd_o,
  output logic [AW-1:0]            rd_addr_o,
  output logic [AW-1:0]            wr_addr_o
);
  import ktp_pkg::*;

  state_e state_q, state_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [CW-1:0] cnt_inc;
  logic [CW-1:0] kk_q, eff;
  logic [CfgW-1:0] cfg_q;
  logic last_q;
  logic accept;

  // limit register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CfgW'(1);
    end else if (cfg_we_i) begin
      cfg_q <= cfg_data_i;
    end
  end

  // limit saturated to table depth
  always_comb begin
    if (int'(cfg_q) > MaxTrades) begin
      eff = CW'(MaxTrades);
    end else begin
      eff = CW'(cfg_q);
    end
  end

  assign accept  = (state_q == ST_IDLE) && in_valid_i;
  assign cnt_inc = cnt_q + CW'(1);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (eff != '0) begin
            state_d = ST_SWEEP;
          end else if (last_day_i) begin
            state_d = ST_FINISH;
          end
        end
      end
      ST_SWEEP: begin
        if (cnt_inc == kk_q) begin
          state_d = last_q ? ST_FINISH : ST_IDLE;
        end
      end
      ST_FINISH: begin
        if (sts_i.out_free) begin
          state_d = ST_CLEAR;
        end
      end
      ST_CLEAR: begin
        if (cnt_q == CW'(MaxTrades - 1)) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // counter restarts on every state change
  always_comb begin
    if (state_d != state_q) begin
      cnt_d = '0;
    end else if ((state_q == ST_SWEEP) || (state_q == ST_CLEAR)) begin
      cnt_d = cnt_inc;
    end else begin
      cnt_d = cnt_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      cnt_q   <= '0;
      kk_q    <= '0;
      last_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      if (accept) begin
        kk_q   <= eff;
        last_q <= last_day_i;
      end
    end
  end

  // outputs
  always_comb begin
    cmd_o.load  = accept;
    cmd_o.sweep = (state_q == ST_SWEEP);
    cmd_o.clear = (state_q == ST_CLEAR);
    cmd_o.emit  = (state_q == ST_FINISH) && sts_i.out_free;
    in_stall_o  = (state_q != ST_IDLE);
    rd_addr_o   = (state_q == ST_SWEEP) ? cnt_inc[AW-1:0] : '0;
    wr_addr_o   = cnt_q[AW-1:0];
  end

`ifndef SYNTHESIS
  a_sweep_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SWEEP) |-> ((kk_q != '0) && (cnt_q < kk_q)))
    else $error("sweep beyond limit");
  a_emit_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.emit |=> (state_q == ST_CLEAR))
    else $error("no clear after result");
  a_clear_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CLEAR) |-> (cnt_q < CW'(MaxTrades)))
    else $error("clear beyond table");
`endif

endmodule
